@@ rtl/sau_pkg.sv @@
`timescale 1ns / 1ps

package sau_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int Q_W         = 32;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_PEEK = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_DIV  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_EMPTY = 3'd1,
    STS_ONE   = 3'd2,
    STS_FULL  = 3'd3,
    STS_DIV0  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  // Per-cell load select: keep, take from the neighbor above, or from below.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PREV = 2'd1,
    CELL_NEXT = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic                  start;
    alu_op_t               op;
    logic signed [Q_W-1:0] q;
    logic signed [Q_W-1:0] p;
  } alu_req_t;

  typedef struct packed {
    logic           done;
    logic           div0;
    logic [Q_W-1:0] result;
  } alu_rsp_t;

endpackage

@@ rtl/stack_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_command, in_push_value
// out      output     out_valid/out_stall out_status, out_top_value, out_stack_depth
//
// Push, peek and error cases: result registered in the cycle after the transaction.
// Add/sub finish in the sau_alu idle state, multiply passes through MUL and MRND;
// the divide is set by the radix-2 quotient loop in sau_alu (32 steps plus check and round).
// One command in flight; the next is taken once the result register is free.
// Synchronous active-low reset empties the stack; entry contents are not cleared.
// A stalled output holds its result and stalls the input side.

module stack_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic signed [31:0] in_push_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_top_value,
  output logic [4:0]  out_stack_depth
);

  localparam int DEPTH = sau_pkg::STACK_DEPTH;
  localparam int CW    = sau_pkg::CNT_W;

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_CALC  = 3'b010,
    T_WRITE = 3'b100
  } top_state_t;

  top_state_t        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  sau_pkg::status_t  out_status_r, out_status_nxt;
  logic [31:0]       out_top_r, out_top_nxt;
  logic [CW-1:0]     out_depth_r, out_depth_nxt;

  logic [31:0]       cell_val [DEPTH];
  sau_pkg::cell_op_t cell_op  [DEPTH];
  logic [31:0]       top_in;
  logic              push_all;
  logic              pop_write;
  logic              accept;
  logic              out_free;
  logic [31:0]       top_cur;
  sau_pkg::alu_req_t alu_req;
  sau_pkg::alu_rsp_t alu_rsp;

  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = (state_r != T_IDLE) | ~out_free;
  assign accept   = in_valid & ~in_stall;
  assign top_cur  = (cnt_r != '0) ? cell_val[0] : 32'd0;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    push_all       = 1'b0;
    pop_write      = 1'b0;
    top_in         = in_push_value;
    alu_req.start  = 1'b0;
    alu_req.op     = sau_pkg::OP_ADD;
    alu_req.q      = cell_val[1];
    alu_req.p      = cell_val[0];

    case (state_r)
      T_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sau_pkg::STS_OK;
          out_top_nxt    = top_cur;
          out_depth_nxt  = cnt_r;
          case (in_command)
            sau_pkg::CMD_PUSH: begin
              if (cnt_r >= CW'(DEPTH)) begin
                out_status_nxt = sau_pkg::STS_FULL;
              end else begin
                push_all      = 1'b1;
                cnt_nxt       = cnt_r + CW'(1);
                out_top_nxt   = in_push_value;
                out_depth_nxt = cnt_r + CW'(1);
              end
            end
            sau_pkg::CMD_PEEK: begin
              if (cnt_r == '0) out_status_nxt = sau_pkg::STS_EMPTY;
            end
            sau_pkg::CMD_ADD, sau_pkg::CMD_SUB, sau_pkg::CMD_MUL, sau_pkg::CMD_DIV: begin
              case (in_command)
                sau_pkg::CMD_ADD: alu_req.op = sau_pkg::OP_ADD;
                sau_pkg::CMD_SUB: alu_req.op = sau_pkg::OP_SUB;
                sau_pkg::CMD_MUL: alu_req.op = sau_pkg::OP_MUL;
                default:          alu_req.op = sau_pkg::OP_DIV;
              endcase
              if (cnt_r == '0) begin
                out_status_nxt = sau_pkg::STS_EMPTY;
              end else if (cnt_r == CW'(1)) begin
                out_status_nxt = sau_pkg::STS_ONE;
              end else begin
                // result goes out only when the ALU finishes
                out_valid_nxt = 1'b0;
                alu_req.start = 1'b1;
                state_nxt     = T_CALC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      T_CALC: begin
        if (alu_rsp.done) state_nxt = T_WRITE;
      end
      T_WRITE: begin
        if (out_free) begin
          pop_write      = 1'b1;
          top_in         = alu_rsp.result;
          cnt_nxt        = cnt_r - CW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = alu_rsp.div0 ? sau_pkg::STS_DIV0 : sau_pkg::STS_OK;
          out_top_nxt    = alu_rsp.result;
          out_depth_nxt  = cnt_r - CW'(1);
          state_nxt      = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  // Cell 0 is the top of stack; push shifts down, an arithmetic write shifts up.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] prev_v;
    logic [31:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = top_in;
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = 32'd0;
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end

    assign cell_op[i] = push_all  ? sau_pkg::CELL_PREV :
                        pop_write ? ((i == 0) ? sau_pkg::CELL_PREV : sau_pkg::CELL_NEXT) :
                                    sau_pkg::CELL_HOLD;

    sau_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_val[i])
    );
  end

  sau_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_top_value   = out_top_r;
  assign out_stack_depth = 5'(out_depth_r);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds stack depth");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != T_IDLE) |-> in_stall)
    else $error("input not stalled while a command is in progress");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == T_CALC))
    else $error("ALU completion outside calc state");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_WRITE && out_free) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("arithmetic write did not drop one entry");

endmodule

@@ rtl/sau_cell.sv @@
`timescale 1ns / 1ps

module sau_cell (
  input  logic                           clk,
  input  sau_pkg::cell_op_t              op,
  input  logic [sau_pkg::Q_W-1:0]        prev_value,
  input  logic [sau_pkg::Q_W-1:0]        next_value,
  output logic [sau_pkg::Q_W-1:0]        value
);

  logic [sau_pkg::Q_W-1:0] value_r;
  logic [sau_pkg::Q_W-1:0] value_nxt;

  always_comb begin
    case (op)
      sau_pkg::CELL_PREV: value_nxt = prev_value;
      sau_pkg::CELL_NEXT: value_nxt = next_value;
      default:            value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ rtl/sau_alu.sv @@
`timescale 1ns / 1ps

module sau_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  sau_pkg::alu_req_t req,
  output sau_pkg::alu_rsp_t rsp
);

  localparam int DIV_STEPS = 32;
  localparam int CW        = $clog2(DIV_STEPS);

  typedef enum logic [5:0] {
    AS_IDLE = 6'b000001,
    AS_MUL  = 6'b000010,
    AS_MRND = 6'b000100,
    AS_DCHK = 6'b001000,
    AS_DIV  = 6'b010000,
    AS_DRND = 6'b100000
  } alu_state_t;

  alu_state_t  state_r, state_nxt;
  logic [31:0] qm_r, qm_nxt;
  logic [31:0] dm_r, dm_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] num_r, num_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] res_r, res_nxt;
  logic        done_r, done_nxt;
  logic        div0_r, div0_nxt;

  logic [32:0] sum;
  logic [32:0] diff;
  logic [31:0] q_mag;
  logic [31:0] p_mag;
  logic [63:0] prod_rnd;
  logic [32:0] trial;
  logic        round_up;
  logic [32:0] quo_rnd;

  function automatic logic [31:0] sat33(input logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else                r = s[31:0];
    return r;
  endfunction

  // Apply sign to an unsigned magnitude and saturate to Q16.16 range.
  function automatic logic [31:0] sat_mag(input logic neg, input logic [47:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag >= 48'h0000_8000_0000) r = 32'h8000_0000;
      else                           r = ~mag[31:0] + 32'd1;
    end else begin
      if (mag > 48'h0000_7FFF_FFFF)  r = 32'h7FFF_FFFF;
      else                           r = mag[31:0];
    end
    return r;
  endfunction

  assign sum      = {req.q[31], req.q} + {req.p[31], req.p};
  assign diff     = {req.q[31], req.q} - {req.p[31], req.p};
  assign q_mag    = req.q[31] ? (~req.q + 32'd1) : req.q;
  assign p_mag    = req.p[31] ? (~req.p + 32'd1) : req.p;
  assign prod_rnd = prod_r + 64'h0000_0000_0000_8000;
  assign trial    = {rem_r, num_r[31]};
  assign round_up = ({rem_r, 1'b0} >= {1'b0, dm_r});
  assign quo_rnd  = {1'b0, quo_r} + {32'd0, round_up};

  always_comb begin
    state_nxt = state_r;
    qm_nxt    = qm_r;
    dm_nxt    = dm_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    div0_nxt  = div0_r;
    done_nxt  = 1'b0;

    case (state_r)
      AS_IDLE: begin
        if (req.start) begin
          qm_nxt   = q_mag;
          dm_nxt   = p_mag;
          neg_nxt  = req.q[31] ^ req.p[31];
          div0_nxt = 1'b0;
          case (req.op)
            sau_pkg::OP_ADD: begin
              res_nxt  = sat33(sum);
              done_nxt = 1'b1;
            end
            sau_pkg::OP_SUB: begin
              res_nxt  = sat33(diff);
              done_nxt = 1'b1;
            end
            sau_pkg::OP_MUL: begin
              state_nxt = AS_MUL;
            end
            default: begin
              if (req.p == '0) begin
                res_nxt  = req.q[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                div0_nxt = 1'b1;
                done_nxt = 1'b1;
              end else begin
                state_nxt = AS_DCHK;
              end
            end
          endcase
        end
      end
      AS_MUL: begin
        prod_nxt  = 64'(qm_r) * 64'(dm_r);
        state_nxt = AS_MRND;
      end
      AS_MRND: begin
        res_nxt   = sat_mag(neg_r, prod_rnd[63:16]);
        done_nxt  = 1'b1;
        state_nxt = AS_IDLE;
      end
      AS_DCHK: begin
        // Upper 16 quotient bits nonzero: the result saturates outright.
        if ({16'd0, qm_r[31:16]} >= dm_r) begin
          res_nxt   = sat_mag(neg_r, 48'h0001_0000_0000);
          done_nxt  = 1'b1;
          state_nxt = AS_IDLE;
        end else begin
          rem_nxt   = {16'd0, qm_r[31:16]};
          num_nxt   = {qm_r[15:0], 16'd0};
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = AS_DIV;
        end
      end
      AS_DIV: begin
        if (trial >= {1'b0, dm_r}) begin
          rem_nxt = 32'(trial - {1'b0, dm_r});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        num_nxt = {num_r[30:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(DIV_STEPS - 1)) state_nxt = AS_DRND;
      end
      AS_DRND: begin
        res_nxt   = sat_mag(neg_r, 48'(quo_rnd));
        done_nxt  = 1'b1;
        state_nxt = AS_IDLE;
      end
      default: begin
        state_nxt = AS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    qm_r   <= qm_nxt;
    dm_r   <= dm_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    div0_r <= div0_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.div0   = div0_r;
  assign rsp.result = res_r;

endmodule
